>>> rtl/vpa_pkg.sv
// Package with the shared codes and state encoding of the partition allocator.
`timescale 1ns / 1ps
package vpa_pkg;

  typedef enum logic [1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_INIT    = 2'd2,
    MODE_NONE    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    FIT_FIRST = 2'd0,
    FIT_WORST = 2'd1,
    FIT_BEST  = 2'd2,
    FIT_ALT   = 2'd3
  } fit_e;

  typedef enum logic [2:0] {
    STAT_OK          = 3'd0,
    STAT_NOFIT       = 3'd1,
    STAT_NOTFOUND    = 3'd2,
    STAT_ALREADYFREE = 3'd3,
    STAT_FULL        = 3'd4
  } status_e;

  typedef enum logic {
    CFG_FIT_POLICY  = 1'b0,
    CFG_MEMORY_SIZE = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_BOOT,
    ST_IDLE,
    ST_SCAN,
    ST_MERGE,
    ST_SHIFT,
    ST_SPLIT_HI,
    ST_SPLIT_LO,
    ST_RESP
  } state_e;

  localparam int          ADDR_BITS      = 16;
  localparam logic [15:0] MEM_SIZE_RESET = 16'd4096;

endpackage

>>> rtl/vpa_table_ram.sv
// Partition table storage: one write port, one registered read port.
`timescale 1ns / 1ps
module vpa_table_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 16,
  parameter int IDX_W = 4
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [IDX_W-1:0] wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic [IDX_W-1:0] rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/variable_partition_allocator_unit.sv
// Top level of the variable partition allocator: control sequencer around the table RAM.
// Sequence: allocate scans the n table entries, plus for a split an entry shift and two
//   writes; release scans, then merges and shifts entries down to close the gap;
//   initialize and unused modes go straight to the response.
// Throughput: one item at a time; the single RAM port pair sets the scan/shift pace.
// Reset: asynchronous, active low; the boot state writes entry 0, then items are taken.
`timescale 1ns / 1ps
module variable_partition_allocator_unit #(
  parameter int MAX_PARTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [15:0] request_size_i,
  input  logic [15:0] release_address_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [15:0] block_address_o,
  // configuration writes
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_wdata_i
);

  localparam int AW    = vpa_pkg::ADDR_BITS;
  localparam int IW    = (MAX_PARTS > 2) ? $clog2(MAX_PARTS) : 1;
  localparam int CW    = $clog2(MAX_PARTS + 1);
  localparam int EW    = 2 * AW + 1;
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_PARTS);
  localparam logic [CW-1:0] ONE     = CW'(1);

  typedef struct packed {
    logic          busy;
    logic [AW-1:0] len;
    logic [AW-1:0] start;
  } entry_t;

  vpa_pkg::state_e state_q, state_d;

  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] iss_q, iss_d;
  logic [CW-1:0] chk_q, chk_d;
  logic          chk_vld_q, chk_vld_d;
  logic          found_q, found_d;
  logic [CW-1:0] pick_q, pick_d;
  entry_t        pick_e_q, pick_e_d;
  entry_t        prev_q, prev_d;

  // entry mover: read src, write dst in the following cycle
  logic [CW-1:0] mv_src_q, mv_src_d;
  logic [CW-1:0] mv_last_q, mv_last_d;
  logic          mv_up_q, mv_up_d;
  logic [CW-1:0] mv_r_q, mv_r_d;
  logic          mv_act_q, mv_act_d;
  logic          wv_q, wv_d;
  logic [CW-1:0] wdst_q, wdst_d;

  logic [1:0]    mode_q, mode_d;
  logic [AW-1:0] req_q, req_d;
  logic [AW-1:0] rel_q, rel_d;
  logic [2:0]    res_st_q, res_st_d;
  logic [AW-1:0] res_addr_q, res_addr_d;

  logic          out_valid_q, out_valid_d;
  logic [2:0]    out_st_q, out_st_d;
  logic [15:0]   out_addr_q, out_addr_d;

  logic [1:0]    policy_q;
  logic [15:0]   msize_q;

  // RAM ports
  logic          wr_en;
  logic [CW-1:0] wr_addr;
  entry_t        wr_data;
  logic [CW-1:0] rd_addr;
  logic [EW-1:0] rd_raw;
  entry_t        rd_data;

  assign rd_data = entry_t'(rd_raw);

  vpa_table_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_PARTS),
    .IDX_W (IW)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr[IW-1:0]),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr[IW-1:0]),
    .rd_data_o (rd_raw)
  );

  // configuration registers, writable at any time
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= vpa_pkg::FIT_FIRST;
      msize_q  <= vpa_pkg::MEM_SIZE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        vpa_pkg::CFG_FIT_POLICY:  policy_q <= cfg_wdata_i[1:0];
        vpa_pkg::CFG_MEMORY_SIZE: msize_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // scan helpers
  logic          hit;
  logic          better;
  logic          take;
  logic          scan_done;
  logic          found_n;
  logic [CW-1:0] pick_n;
  entry_t        pick_e_n;
  // merge helpers
  logic          nf;
  logic          pf;
  logic [AW-1:0] merged_len;
  logic [CW-1:0] rm_cnt;
  logic [CW-1:0] rm_base;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    iss_d       = iss_q;
    chk_d       = chk_q;
    chk_vld_d   = 1'b0;
    found_d     = found_q;
    pick_d      = pick_q;
    pick_e_d    = pick_e_q;
    prev_d      = prev_q;
    mv_src_d    = mv_src_q;
    mv_last_d   = mv_last_q;
    mv_up_d     = mv_up_q;
    mv_r_d      = mv_r_q;
    mv_act_d    = mv_act_q;
    wv_d        = 1'b0;
    wdst_d      = wdst_q;
    mode_d      = mode_q;
    req_d       = req_q;
    rel_d       = rel_q;
    res_st_d    = res_st_q;
    res_addr_d  = res_addr_q;
    out_valid_d = out_valid_q;
    out_st_d    = out_st_q;
    out_addr_d  = out_addr_q;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = '0;
    rd_addr     = iss_q;
    in_ready_o  = 1'b0;

    // compare the entry coming back from the RAM
    if (mode_q == vpa_pkg::MODE_ALLOC) begin
      hit = chk_vld_q && !rd_data.busy && (rd_data.len >= req_q) && (req_q != '0);
    end else begin
      hit = chk_vld_q && (rd_data.start == rel_q);
    end
    case (policy_q)
      vpa_pkg::FIT_FIRST: better = 1'b0;
      vpa_pkg::FIT_WORST: better = rd_data.len > pick_e_q.len;
      default:            better = rd_data.len < pick_e_q.len;
    endcase
    take      = hit && (!found_q || better);
    found_n   = found_q || take;
    pick_n    = take ? chk_q : pick_q;
    pick_e_n  = take ? rd_data : pick_e_q;
    scan_done = chk_vld_q && ((hit && (policy_q == vpa_pkg::FIT_FIRST ||
                                       mode_q != vpa_pkg::MODE_ALLOC)) ||
                              (chk_q == cnt_q - ONE));

    // release merge: rd_data holds entry k+1 in ST_MERGE
    nf         = ((pick_q + ONE) < cnt_q) && !rd_data.busy;
    pf         = (pick_q != '0) && !prev_q.busy;
    merged_len = pick_e_q.len + (nf ? rd_data.len : '0);
    rm_cnt     = CW'(nf) + CW'(pf);
    rm_base    = pf ? pick_q : pick_q + ONE;

    // drain the result register
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    // pending move write
    if (wv_q) begin
      wr_en   = 1'b1;
      wr_addr = wdst_q;
      wr_data = rd_data;
    end

    case (state_q)
      vpa_pkg::ST_BOOT: begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = '{busy: 1'b0, len: AW'(msize_q), start: '0};
        cnt_d   = ONE;
        state_d = vpa_pkg::ST_IDLE;
      end

      vpa_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          mode_d     = mode_i;
          req_d      = AW'(request_size_i);
          rel_d      = AW'(release_address_i);
          res_st_d   = vpa_pkg::STAT_OK;
          res_addr_d = '0;
          iss_d      = '0;
          found_d    = 1'b0;
          case (mode_i)
            vpa_pkg::MODE_ALLOC, vpa_pkg::MODE_RELEASE: state_d = vpa_pkg::ST_SCAN;
            vpa_pkg::MODE_INIT: begin
              wr_en   = 1'b1;
              wr_addr = '0;
              wr_data = '{busy: 1'b0, len: AW'(msize_q), start: '0};
              cnt_d   = ONE;
              state_d = vpa_pkg::ST_RESP;
            end
            default: state_d = vpa_pkg::ST_RESP;
          endcase
        end
      end

      vpa_pkg::ST_SCAN: begin
        // issue the next read while checking the previous one
        if (iss_q < cnt_q) begin
          iss_d     = iss_q + ONE;
          chk_d     = iss_q;
          chk_vld_d = 1'b1;
        end
        if (take) begin
          found_d  = 1'b1;
          pick_d   = chk_q;
          pick_e_d = rd_data;
        end
        if (chk_vld_q && !scan_done) begin
          prev_d = rd_data;
        end
        if (scan_done) begin
          chk_vld_d = 1'b0;
          if (mode_q == vpa_pkg::MODE_ALLOC) begin
            if (!found_n) begin
              res_st_d = vpa_pkg::STAT_NOFIT;
              state_d  = vpa_pkg::ST_RESP;
            end else if (pick_e_n.len == req_q) begin
              // exact fit: mark busy in place
              wr_en      = 1'b1;
              wr_addr    = pick_n;
              wr_data    = '{busy: 1'b1, len: pick_e_n.len, start: pick_e_n.start};
              res_addr_d = pick_e_n.start;
              state_d    = vpa_pkg::ST_RESP;
            end else if (cnt_q >= CNT_MAX) begin
              res_st_d = vpa_pkg::STAT_FULL;
              state_d  = vpa_pkg::ST_RESP;
            end else if ((pick_n + ONE) < cnt_q) begin
              // open a slot after the pick: move entries up, top first
              mv_src_d  = cnt_q - ONE;
              mv_last_d = pick_n + ONE;
              mv_up_d   = 1'b1;
              mv_act_d  = 1'b1;
              state_d   = vpa_pkg::ST_SHIFT;
            end else begin
              state_d = vpa_pkg::ST_SPLIT_HI;
            end
          end else begin
            if (!hit) begin
              res_st_d = vpa_pkg::STAT_NOTFOUND;
              state_d  = vpa_pkg::ST_RESP;
            end else if (!rd_data.busy) begin
              res_st_d = vpa_pkg::STAT_ALREADYFREE;
              state_d  = vpa_pkg::ST_RESP;
            end else begin
              rd_addr = chk_q + ONE;
              state_d = vpa_pkg::ST_MERGE;
            end
          end
        end
      end

      vpa_pkg::ST_MERGE: begin
        wr_en = 1'b1;
        if (pf) begin
          wr_addr = pick_q - ONE;
          wr_data = '{busy: 1'b0, len: prev_q.len + merged_len, start: prev_q.start};
        end else begin
          wr_addr = pick_q;
          wr_data = '{busy: 1'b0, len: merged_len, start: pick_e_q.start};
        end
        cnt_d = cnt_q - rm_cnt;
        if ((rm_cnt != '0) && ((rm_base + rm_cnt) < cnt_q)) begin
          // close the gap: move entries down, bottom first
          mv_src_d  = rm_base + rm_cnt;
          mv_last_d = cnt_q - ONE;
          mv_up_d   = 1'b0;
          mv_r_d    = rm_cnt;
          mv_act_d  = 1'b1;
          state_d   = vpa_pkg::ST_SHIFT;
        end else begin
          state_d = vpa_pkg::ST_RESP;
        end
      end

      vpa_pkg::ST_SHIFT: begin
        if (mv_act_q) begin
          rd_addr = mv_src_q;
          wv_d    = 1'b1;
          wdst_d  = mv_up_q ? mv_src_q + ONE : mv_src_q - mv_r_q;
          if (mv_src_q == mv_last_q) begin
            mv_act_d = 1'b0;
          end else begin
            mv_src_d = mv_up_q ? mv_src_q - ONE : mv_src_q + ONE;
          end
        end else if (wv_q) begin
          state_d = mv_up_q ? vpa_pkg::ST_SPLIT_HI : vpa_pkg::ST_RESP;
        end
      end

      vpa_pkg::ST_SPLIT_HI: begin
        // free remainder right after the block
        wr_en   = 1'b1;
        wr_addr = pick_q + ONE;
        wr_data = '{busy: 1'b0, len: pick_e_q.len - req_q, start: pick_e_q.start + req_q};
        cnt_d   = cnt_q + ONE;
        state_d = vpa_pkg::ST_SPLIT_LO;
      end

      vpa_pkg::ST_SPLIT_LO: begin
        wr_en      = 1'b1;
        wr_addr    = pick_q;
        wr_data    = '{busy: 1'b1, len: req_q, start: pick_e_q.start};
        res_addr_d = pick_e_q.start;
        state_d    = vpa_pkg::ST_RESP;
      end

      vpa_pkg::ST_RESP: begin
        // hold until the result register is free
        if (!out_valid_q) begin
          out_valid_d = 1'b1;
          out_st_d    = res_st_q;
          out_addr_d  = 16'(res_addr_q);
          state_d     = vpa_pkg::ST_IDLE;
        end
      end

      default: state_d = vpa_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vpa_pkg::ST_BOOT;
      cnt_q       <= ONE;
      iss_q       <= '0;
      chk_vld_q   <= 1'b0;
      found_q     <= 1'b0;
      mv_act_q    <= 1'b0;
      wv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      iss_q       <= iss_d;
      chk_vld_q   <= chk_vld_d;
      found_q     <= found_d;
      mv_act_q    <= mv_act_d;
      wv_q        <= wv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_q      <= chk_d;
    pick_q     <= pick_d;
    pick_e_q   <= pick_e_d;
    prev_q     <= prev_d;
    mv_src_q   <= mv_src_d;
    mv_last_q  <= mv_last_d;
    mv_up_q    <= mv_up_d;
    mv_r_q     <= mv_r_d;
    wdst_q     <= wdst_d;
    mode_q     <= mode_d;
    req_q      <= req_d;
    rel_q      <= rel_d;
    res_st_q   <= res_st_d;
    res_addr_q <= res_addr_d;
    out_st_q   <= out_st_d;
    out_addr_q <= out_addr_d;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_st_q;
  assign block_address_o = out_addr_q;

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) && (cnt_q <= CNT_MAX))
    else $error("partition count out of range");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q != vpa_pkg::ST_IDLE))
    else $error("accepted item did not start work");

  a_scan_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == vpa_pkg::ST_SCAN && !scan_done) |-> !wr_en)
    else $error("table written during scan");

  a_out_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i) |=> !out_valid_o)
    else $error("result register reloaded while full");
`endif

endmodule

>>> tb/tb_variable_partition_allocator_unit.sv
// Testbench for the variable partition allocator: table-driven directed items plus random traffic.
`timescale 1ns / 1ps
module tb_variable_partition_allocator_unit;

  localparam int NPARTS = 16;
  localparam int LATENCY = 2 * NPARTS + 16;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  mode_i = '0;
  logic [15:0] request_size_i = '0;
  logic [15:0] release_address_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic [15:0] block_address_o;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  variable_partition_allocator_unit DUT (.*);

  // 12 ns period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predictor copy of the partition table and registers
  logic [15:0]   tbl_start [NPARTS];
  logic [15:0]   tbl_len   [NPARTS];
  logic          tbl_busy  [NPARTS];
  int            tbl_count;
  vpa_pkg::fit_e pol;
  logic [15:0]   mem_sz;

  typedef struct packed {
    vpa_pkg::status_e st;
    logic [15:0]      addr;
  } answer_t;

  answer_t answers_due[$];
  int      errors = 0;
  int      n_sent = 0;
  int      n_got = 0;
  int      n_ok = 0, n_nofit = 0, n_full = 0, n_notfound = 0, n_free = 0;
  bit      hold_off = 1'b0;

  // Directed table: a check flag marks rows whose answer is typed in
  typedef struct {
    vpa_pkg::mode_e   md;
    logic [15:0]      req;
    logic [15:0]      rel;
    bit               chk;
    vpa_pkg::status_e st;
    logic [15:0]      addr;
  } row_t;

  function automatic void table_reset(logic [15:0] len);
    for (int i = 0; i < NPARTS; i++) begin
      tbl_start[i] = '0;
      tbl_len[i]   = '0;
      tbl_busy[i]  = 1'b0;
    end
    tbl_len[0] = len;
    tbl_count = 1;
  endfunction

  function automatic void drop_entry(int k);
    for (int i = k; i + 1 < tbl_count; i++) begin
      tbl_start[i] = tbl_start[i+1];
      tbl_len[i]   = tbl_len[i+1];
      tbl_busy[i]  = tbl_busy[i+1];
    end
    tbl_count--;
    tbl_start[tbl_count] = '0;
    tbl_len[tbl_count]   = '0;
    tbl_busy[tbl_count]  = 1'b0;
  endfunction

  function automatic answer_t predict_alloc(logic [15:0] req);
    answer_t a;
    int      pick;
    bit      found;
    a.st = vpa_pkg::STAT_OK;
    a.addr = '0;
    pick = 0;
    found = 1'b0;
    if (req == 0) begin
      a.st = vpa_pkg::STAT_NOFIT;
      return a;
    end
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_busy[i] || tbl_len[i] < req) continue;
      if (!found) begin
        pick = i;
        found = 1'b1;
        if (pol == vpa_pkg::FIT_FIRST) break;
      end else if (pol == vpa_pkg::FIT_WORST) begin
        if (tbl_len[i] > tbl_len[pick]) pick = i;
      end else begin
        if (tbl_len[i] < tbl_len[pick]) pick = i;
      end
    end
    if (!found) begin
      a.st = vpa_pkg::STAT_NOFIT;
      return a;
    end
    if (tbl_len[pick] == req) begin
      tbl_busy[pick] = 1'b1;
      a.addr = tbl_start[pick];
      return a;
    end
    if (tbl_count >= NPARTS) begin
      a.st = vpa_pkg::STAT_FULL;
      return a;
    end
    for (int i = tbl_count; i > pick; i--) begin
      tbl_start[i] = tbl_start[i-1];
      tbl_len[i]   = tbl_len[i-1];
      tbl_busy[i]  = tbl_busy[i-1];
    end
    tbl_count++;
    tbl_len[pick] = req;
    tbl_busy[pick] = 1'b1;
    tbl_start[pick+1] = tbl_start[pick] + req;
    tbl_len[pick+1] = tbl_len[pick+1] - req;
    tbl_busy[pick+1] = 1'b0;
    a.addr = tbl_start[pick];
    return a;
  endfunction

  function automatic vpa_pkg::status_e predict_release(logic [15:0] adr);
    int k;
    k = -1;
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_start[i] == adr) begin
        k = i;
        break;
      end
    end
    if (k < 0) return vpa_pkg::STAT_NOTFOUND;
    if (!tbl_busy[k]) return vpa_pkg::STAT_ALREADYFREE;
    tbl_busy[k] = 1'b0;
    if (k + 1 < tbl_count && !tbl_busy[k+1]) begin
      tbl_len[k] = tbl_len[k] + tbl_len[k+1];
      drop_entry(k + 1);
    end
    if (k > 0 && !tbl_busy[k-1]) begin
      tbl_len[k-1] = tbl_len[k-1] + tbl_len[k];
      drop_entry(k);
    end
    return vpa_pkg::STAT_OK;
  endfunction

  function automatic answer_t predict_item(logic [1:0] md, logic [15:0] req, logic [15:0] rel);
    answer_t a;
    a.st = vpa_pkg::STAT_OK;
    a.addr = '0;
    case (vpa_pkg::mode_e'(md))
      vpa_pkg::MODE_ALLOC:   a = predict_alloc(req);
      vpa_pkg::MODE_RELEASE: a.st = predict_release(rel);
      vpa_pkg::MODE_INIT:    table_reset(mem_sz);
      default:               ;
    endcase
    return a;
  endfunction

  // Send one item after a random gap; hold the payload until accepted
  task automatic send_item(logic [1:0] md, logic [15:0] req, logic [15:0] rel);
    int gap;
    gap = $urandom_range(0, 8);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= md;
    request_size_i <= req;
    release_address_i <= rel;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    answers_due.push_back(predict_item(md, req, rel));
    n_sent++;
    @(negedge clk_i);
  endtask

  // Drop valid, wait for every answer, then let the block settle before a register write
  task automatic drain_and_settle();
    in_valid_i <= 1'b0;
    while (answers_due.size() != 0) @(negedge clk_i);
    repeat (LATENCY) @(negedge clk_i);
  endtask

  task automatic write_reg(vpa_pkg::cfg_idx_e idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == vpa_pkg::CFG_FIT_POLICY) pol = vpa_pkg::fit_e'(val[1:0]);
    else mem_sz = val;
  endtask

  // Pick a start that is mostly a live busy partition, sometimes noise
  function automatic logic [15:0] pick_release();
    int k;
    if ($urandom_range(0, 9) < 8) begin
      k = $urandom_range(0, tbl_count - 1);
      for (int i = 0; i < tbl_count; i++)
        if (tbl_busy[(k + i) % tbl_count]) return tbl_start[(k + i) % tbl_count];
      return tbl_start[k];
    end
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return 16'($urandom);
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom_range(1, 16));
      default: return 16'($urandom_range(1, 600));
    endcase
  endfunction

  // Result checker: sample at the rising edge, compare against the oldest answer
  always @(posedge clk_i) begin
    answer_t exp_a;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_got++;
      if (answers_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual status=%0d addr=%0d",
                 $time, status_o, block_address_o);
      end else begin
        exp_a = answers_due.pop_front();
        case (exp_a.st)
          vpa_pkg::STAT_OK:       n_ok++;
          vpa_pkg::STAT_NOFIT:    n_nofit++;
          vpa_pkg::STAT_FULL:     n_full++;
          vpa_pkg::STAT_NOTFOUND: n_notfound++;
          default:                n_free++;
        endcase
        if (status_o !== exp_a.st) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, exp_a.st, status_o);
        end
        if (block_address_o !== exp_a.addr) begin
          errors++;
          $display("%0t: block_address expected %0d actual %0d", $time, exp_a.addr,
                   block_address_o);
        end
      end
    end
  end

  // Receiver: random stalls per item, plus a long hold-off on request
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_ready_i <= 1'b0;
        repeat (300) @(negedge clk_i);
        hold_off = 1'b0;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
        @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // Stimulus
  initial begin
    row_t    dir[$];
    answer_t got;
    int      phase_len;
    pol = vpa_pkg::FIT_FIRST;
    mem_sz = vpa_pkg::MEM_SIZE_RESET;
    table_reset(vpa_pkg::MEM_SIZE_RESET);
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed rows; checked rows have a typed-in answer compared with the predictor
    dir = '{
      '{vpa_pkg::MODE_ALLOC,   16'd0,    16'd0,    1, vpa_pkg::STAT_NOFIT,       16'd0},
      '{vpa_pkg::MODE_ALLOC,   16'd4097, 16'd0,    1, vpa_pkg::STAT_NOFIT,       16'd0},
      '{vpa_pkg::MODE_ALLOC,   16'hFFFF, 16'd0,    1, vpa_pkg::STAT_NOFIT,       16'd0},
      '{vpa_pkg::MODE_ALLOC,   16'd100,  16'd0,    1, vpa_pkg::STAT_OK,          16'd0},
      '{vpa_pkg::MODE_ALLOC,   16'd200,  16'd0,    1, vpa_pkg::STAT_OK,          16'd100},
      '{vpa_pkg::MODE_ALLOC,   16'd50,   16'd0,    1, vpa_pkg::STAT_OK,          16'd300},
      '{vpa_pkg::MODE_RELEASE, 16'd0,    16'd7,    1, vpa_pkg::STAT_NOTFOUND,    16'd0},
      '{vpa_pkg::MODE_RELEASE, 16'd0,    16'hFFFF, 1, vpa_pkg::STAT_NOTFOUND,    16'd0},
      '{vpa_pkg::MODE_RELEASE, 16'd0,    16'd350,  1, vpa_pkg::STAT_ALREADYFREE, 16'd0},
      '{vpa_pkg::MODE_RELEASE, 16'd0,    16'd100,  1, vpa_pkg::STAT_OK,          16'd0},
      '{vpa_pkg::MODE_RELEASE, 16'd0,    16'd100,  1, vpa_pkg::STAT_ALREADYFREE, 16'd0},
      '{vpa_pkg::MODE_RELEASE, 16'd0,    16'd0,    1, vpa_pkg::STAT_OK,          16'd0},
      '{vpa_pkg::MODE_ALLOC,   16'd300,  16'd0,    0, vpa_pkg::STAT_OK,          16'd0},
      '{vpa_pkg::MODE_RELEASE, 16'd0,    16'd300,  0, vpa_pkg::STAT_OK,          16'd0},
      '{vpa_pkg::MODE_NONE,    16'hFFFF, 16'hFFFF, 1, vpa_pkg::STAT_OK,          16'd0},
      '{vpa_pkg::MODE_INIT,    16'd0,    16'd0,    1, vpa_pkg::STAT_OK,          16'd0},
      '{vpa_pkg::MODE_ALLOC,   16'd4096, 16'd0,    1, vpa_pkg::STAT_OK,          16'd0},
      '{vpa_pkg::MODE_ALLOC,   16'd1,    16'd0,    1, vpa_pkg::STAT_NOFIT,       16'd0},
      '{vpa_pkg::MODE_RELEASE, 16'd0,    16'd0,    1, vpa_pkg::STAT_OK,          16'd0},
      '{vpa_pkg::MODE_INIT,    16'h5555, 16'hAAAA, 1, vpa_pkg::STAT_OK,          16'd0}
    };
    foreach (dir[i]) begin
      // predict on a scratch copy to cross-check the typed answer
      got = predict_item_peek(dir[i].md, dir[i].req, dir[i].rel);
      if (dir[i].chk && got !== {dir[i].st, dir[i].addr}) begin
        errors++;
        $display("%0t: directed row %0d expected %0d/%0d predictor %0d/%0d", $time, i,
                 dir[i].st, dir[i].addr, got.st, got.addr);
      end
      send_item(dir[i].md, dir[i].req, dir[i].rel);
    end

    // Fill the table with small splits so the full-table case shows up
    for (int i = 0; i < NPARTS + 2; i++) send_item(vpa_pkg::MODE_ALLOC, 16'd3, 16'd0);
    send_item(vpa_pkg::MODE_ALLOC, 16'd3, 16'd0);
    send_item(vpa_pkg::MODE_RELEASE, 16'd0, 16'd3);
    send_item(vpa_pkg::MODE_ALLOC, 16'd3, 16'd0);

    // Random phases, each under a new register setting
    for (int ph = 0; ph < 8; ph++) begin
      drain_and_settle();
      case (ph)
        0: begin
          write_reg(vpa_pkg::CFG_FIT_POLICY, 16'(vpa_pkg::FIT_WORST));
          write_reg(vpa_pkg::CFG_MEMORY_SIZE, 16'hFFFF);
        end
        1: begin
          write_reg(vpa_pkg::CFG_FIT_POLICY, 16'(vpa_pkg::FIT_BEST));
          write_reg(vpa_pkg::CFG_MEMORY_SIZE, 16'd1);
        end
        2: begin
          write_reg(vpa_pkg::CFG_FIT_POLICY, 16'(vpa_pkg::FIT_ALT));
          write_reg(vpa_pkg::CFG_MEMORY_SIZE, 16'd0);
        end
        3: begin
          write_reg(vpa_pkg::CFG_FIT_POLICY, 16'(vpa_pkg::FIT_FIRST));
          write_reg(vpa_pkg::CFG_MEMORY_SIZE, 16'd2000);
        end
        default: begin
          write_reg(vpa_pkg::CFG_FIT_POLICY, 16'($urandom_range(0, 3)));
          write_reg(vpa_pkg::CFG_MEMORY_SIZE, 16'($urandom));
        end
      endcase
      send_item(vpa_pkg::MODE_INIT, 16'($urandom), 16'($urandom));
      if (ph == 1) write_reg_hold();
      phase_len = 135;
      for (int j = 0; j < phase_len; j++) begin
        if (ph == 4 && j == 20) hold_off = 1'b1;
        case ($urandom_range(0, 19))
          0:               send_item(vpa_pkg::MODE_INIT, 16'($urandom), 16'($urandom));
          1:               send_item(vpa_pkg::MODE_NONE, 16'($urandom), 16'($urandom));
          2,3,4,5,6,7,8,9: send_item(vpa_pkg::MODE_ALLOC, pick_size(), 16'($urandom));
          default:         send_item(vpa_pkg::MODE_RELEASE, 16'($urandom), pick_release());
        endcase
      end
    end
    drain_and_settle();
    $display("Sent %0d items, checked %0d results: %0d ok, %0d no fit, %0d full,",
             n_sent, n_got, n_ok, n_nofit, n_full);
    $display("  %0d unknown address, %0d already free, across 4 fit policies", n_notfound,
             n_free);
    if (errors == 0 && answers_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // After a size-1 memory, write memory size again while idle so the register sees a mid value
  task automatic write_reg_hold();
    drain_and_settle();
    write_reg(vpa_pkg::CFG_MEMORY_SIZE, 16'd800);
    send_item(vpa_pkg::MODE_INIT, 16'd0, 16'd0);
  endtask

  // Evaluate an item on a copy of the table without disturbing it
  function automatic answer_t predict_item_peek(logic [1:0] md, logic [15:0] req,
                                                logic [15:0] rel);
    logic [15:0] s_start [NPARTS];
    logic [15:0] s_len   [NPARTS];
    logic        s_busy  [NPARTS];
    int          s_count;
    answer_t     a;
    s_start = tbl_start;
    s_len = tbl_len;
    s_busy = tbl_busy;
    s_count = tbl_count;
    a = predict_item(md, req, rel);
    tbl_start = s_start;
    tbl_len = s_len;
    tbl_busy = s_busy;
    tbl_count = s_count;
    return a;
  endfunction

  // Watchdog
  initial begin
    #(12 * 400000);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
